@@ hw/rtl/cts_pkg.sv @@
// Shared constants, types and frequency tables for the channel-to-synthesizer
// tuning block. No dependencies; used by every other file of the block.
`default_nettype none

package cts_pkg;

   // Storage sizing
   localparam int CUSTOM_ENTRIES = 8;
   localparam int FREQ_BITS      = 13;
   localparam int CE_IDX_W       = (CUSTOM_ENTRIES > 1) ? $clog2(CUSTOM_ENTRIES) : 1;

   // Field widths on the channels
   localparam int CMD_W      = 1;
   localparam int CHANNEL_W  = 6;
   localparam int ENTRY_W    = 3;
   localparam int NEWFREQ_W  = 13;
   localparam int FRAME_W    = 25;
   localparam int TUNED_W    = 13;
   localparam int STATUS_W   = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Synthesizer word
   localparam int                     LO_OFFSET    = 479;
   localparam logic [3:0]             SYNTH_ADDR   = 4'h1;
   localparam int                     DATA_W       = 20;
   localparam logic [FREQ_BITS-1:0]   DEFAULT_FREQ = FREQ_BITS'(5800);
   localparam logic [CHANNEL_W-1:0]   MAX_CHANNEL  = CHANNEL_W'(55);
   localparam logic [2:0]             CUSTOM_BAND  = 3'd6;
   localparam logic [2:0]             L_BAND       = 3'd5;

   // Commands
   localparam logic [CMD_W-1:0] CMD_TUNE  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

   // Register indexes
   localparam logic REG_L_ALT  = 1'b0;
   localparam logic REG_LOCKED = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_SENT     = 2'd0,
      ST_LOCKED   = 2'd1,
      ST_REJECTED = 2'd2,
      ST_WRITTEN  = 2'd3
   } status_type;

   typedef logic [FREQ_BITS-1:0] freq_type;

   localparam logic [12:0] BAND_TABLE [6][8] = '{
      '{13'd5865, 13'd5845, 13'd5825, 13'd5805, 13'd5785, 13'd5765, 13'd5745, 13'd5725},
      '{13'd5733, 13'd5752, 13'd5771, 13'd5790, 13'd5809, 13'd5828, 13'd5847, 13'd5866},
      '{13'd5705, 13'd5685, 13'd5665, 13'd5645, 13'd5885, 13'd5905, 13'd5925, 13'd5945},
      '{13'd5740, 13'd5760, 13'd5780, 13'd5800, 13'd5820, 13'd5840, 13'd5860, 13'd5880},
      '{13'd5658, 13'd5695, 13'd5732, 13'd5769, 13'd5806, 13'd5843, 13'd5880, 13'd5917},
      '{13'd5362, 13'd5399, 13'd5436, 13'd5473, 13'd5510, 13'd5547, 13'd5584, 13'd5621}
   };

   localparam logic [12:0] L_ALT_TABLE [8] = '{
      13'd5333, 13'd5373, 13'd5413, 13'd5453, 13'd5493, 13'd5533, 13'd5573, 13'd5613
   };

   // Fixed grid lookup for bands 0..5; anything else falls back to the default
   function automatic freq_type fixed_freq(input logic [2:0] band, input logic [2:0] slot);
      freq_type f;
      f = DEFAULT_FREQ;
      if (band < 3'd6) begin
         f = FREQ_BITS'(BAND_TABLE[band][slot]);
      end
      return f;
   endfunction

   function automatic freq_type l_alt_freq(input logic [2:0] slot);
      return FREQ_BITS'(L_ALT_TABLE[slot]);
   endfunction

   // Power-up contents of custom slot i
   function automatic freq_type custom_reset(input int i);
      return FREQ_BITS'(5740 + 20 * i);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cts_req_if.sv @@
// Command channel carrying channel selects and custom slot writes.
// Depends on cts_pkg for field widths.
`default_nettype none

interface cts_req_if;
   logic                              valid;
   logic                              ready;
   logic [cts_pkg::CMD_W-1:0]         cmd;
   logic [cts_pkg::CHANNEL_W-1:0]     channel;
   logic [cts_pkg::ENTRY_W-1:0]       entry;
   logic [cts_pkg::NEWFREQ_W-1:0]     new_freq;

   modport source (output valid, cmd, channel, entry, new_freq, input ready);
   modport sink   (input valid, cmd, channel, entry, new_freq, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cts_rsp_if.sv @@
// Result channel carrying the synthesizer word, tuned frequency and status.
// Depends on cts_pkg for field widths.
`default_nettype none

interface cts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cts_pkg::FRAME_W-1:0]       frame;
   logic [cts_pkg::TUNED_W-1:0]       tuned_freq;
   logic [cts_pkg::STATUS_W-1:0]      status;

   modport source (output valid, frame, tuned_freq, status, input ready);
   modport sink   (input valid, frame, tuned_freq, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cts_frame_build.sv @@
// Converts a frequency in MHz into the 25-bit synthesizer register word.
// Depends on cts_pkg.
`default_nettype none

module cts_frame_build (
   input  wire logic [cts_pkg::FREQ_BITS-1:0] freq,
   output logic      [cts_pkg::FRAME_W-1:0]   frame
);
   import cts_pkg::*;

   logic [FREQ_BITS-1:0] lo;
   logic [FREQ_BITS+1:0] data_wide;
   logic [DATA_W-1:0]    data;

   always_comb begin
      // LO saturates at zero below the offset
      if (freq >= FREQ_BITS'(LO_OFFSET)) begin
         lo = (freq - FREQ_BITS'(LO_OFFSET)) >> 1;
      end else begin
         lo = '0;
      end
      // N = lo/32 lands at bit 7, A = lo%32 at bit 0
      data_wide = {lo[FREQ_BITS-1:5], 7'b0} | (FREQ_BITS+2)'(lo[4:0]);
      data      = DATA_W'(data_wide);
      frame     = {data, 1'b1, SYNTH_ADDR};
   end

endmodule

`default_nettype wire

@@ hw/rtl/channel_to_synth_frame.sv @@
// Channel-to-synthesizer tuning block for a 5.8 GHz video receiver.
// Depends on cts_pkg, cts_req_if, cts_rsp_if and cts_frame_build.
//
// Usage:
//   req_bus (valid/ready) takes one command per beat: a channel select
//   (cmd 0) that looks up the frequency and builds the synthesizer word, or a
//   custom slot write (cmd 1) that stores new_freq in the band 6 table.
//   rsp_bus returns exactly one beat per command: frame (0 when nothing is
//   sent), the frequency last sent, and a status code.
//   csr_* is an APB-style port: offset 0 selects the alternate L band grid,
//   offset 4 locks tuning. Write registers only while no command is in flight.
// Timing:
//   A command is registered on acceptance and its result is registered when it
//   moves on from the input register to the result register. One command per
//   cycle is sustained while rsp_bus.ready stays high; the table read and frame
//   arithmetic sit between the input register and the result register.
// Reset:
//   Synchronous. Both channels empty, configuration registers cleared, custom slots back to
//   5740..5880 MHz in 20 MHz steps, last frequency 5800 MHz.
// Back-pressure:
//   While rsp_bus.ready is low the result holds; one more command still
//   enters the input register, then req_bus.ready drops.
`default_nettype none

module channel_to_synth_frame (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cts_req_if.sink                             req_bus,
   cts_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [cts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cts_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import cts_pkg::*;

   // Configuration
   logic l_alt_ff,  l_alt_in;
   logic locked_ff, locked_in;
   logic csr_write;

   // Input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]      s1_cmd_ff;
   logic [CHANNEL_W-1:0]  s1_channel_ff;
   logic [ENTRY_W-1:0]    s1_entry_ff;
   logic [NEWFREQ_W-1:0]  s1_new_freq_ff;

   // Block state
   freq_type custom_ff [CUSTOM_ENTRIES];
   freq_type last_freq_ff, last_freq_in;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [TUNED_W-1:0] tuned_ff;
   status_type         status_ff, status_in;

   logic               req_take;
   logic               advance;
   logic [2:0]         band;
   logic [2:0]         slot;
   logic [4:0]         slot_ext;
   logic [4:0]         entry_ext;
   logic               custom_we;
   freq_type           freq;
   logic [FRAME_W-1:0] built_frame;

   cts_frame_build u_frame (
      .freq  (freq),
      .frame (built_frame)
   );

   // APB configuration; one register per word, index from paddr[2]
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      l_alt_in  = l_alt_ff;
      locked_in = locked_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_L_ALT:  l_alt_in  = csr_pwdata[0];
            REG_LOCKED: locked_in = csr_pwdata[0];
            default:    l_alt_in  = l_alt_ff;
         endcase
      end
      case (csr_paddr[2])
         REG_L_ALT:  csr_prdata = CSR_DATA_W'(l_alt_ff);
         REG_LOCKED: csr_prdata = CSR_DATA_W'(locked_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Handshake: the item in the input register moves on when the result slot frees
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Frequency lookup for the registered command
   assign band      = s1_channel_ff[5:3];
   assign slot      = s1_channel_ff[2:0];
   assign slot_ext  = {2'b0, slot};
   assign entry_ext = {2'b0, s1_entry_ff};

   always_comb begin
      if (band == CUSTOM_BAND) begin
         if (slot_ext < 5'(CUSTOM_ENTRIES)) begin
            freq = custom_ff[slot_ext[CE_IDX_W-1:0]];
         end else begin
            freq = DEFAULT_FREQ;
         end
      end else if (band == L_BAND && l_alt_ff) begin
         freq = l_alt_freq(slot);
      end else begin
         freq = fixed_freq(band, slot);
      end
   end

   // Command decode
   always_comb begin
      frame_in     = '0;
      last_freq_in = last_freq_ff;
      custom_we    = 1'b0;
      if (s1_cmd_ff == CMD_WRITE) begin
         status_in = ST_WRITTEN;
         custom_we = advance && (entry_ext < 5'(CUSTOM_ENTRIES));
      end else if (s1_channel_ff > MAX_CHANNEL) begin
         status_in = ST_REJECTED;
      end else if (locked_ff) begin
         status_in = ST_LOCKED;
      end else begin
         status_in    = ST_SENT;
         frame_in     = built_frame;
         last_freq_in = freq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_alt_ff     <= 1'b0;
         locked_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_freq_ff <= DEFAULT_FREQ;
         for (int i = 0; i < CUSTOM_ENTRIES; i++) begin
            custom_ff[i] <= custom_reset(i);
         end
      end else begin
         l_alt_ff     <= l_alt_in;
         locked_ff    <= locked_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            last_freq_ff <= last_freq_in;
         end
         if (custom_we) begin
            custom_ff[entry_ext[CE_IDX_W-1:0]] <= FREQ_BITS'(s1_new_freq_ff);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff      <= req_bus.cmd;
         s1_channel_ff  <= req_bus.channel;
         s1_entry_ff    <= req_bus.entry;
         s1_new_freq_ff <= req_bus.new_freq;
      end
      if (advance) begin
         frame_ff  <= frame_in;
         tuned_ff  <= TUNED_W'(last_freq_in);
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.frame      = frame_ff;
   assign rsp_bus.tuned_freq = tuned_ff;
   assign rsp_bus.status     = status_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   a_sent_header : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff == ST_SENT) |-> (frame_ff[3:0] == SYNTH_ADDR && frame_ff[4]))
      else $error("sent frame lacks address and write bit");

   a_no_frame : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff != ST_SENT) |-> (frame_ff == '0))
      else $error("frame present on a result that sends nothing");

   a_last_freq : assert property (@(posedge clock) disable iff (reset)
      (advance && s1_cmd_ff == CMD_WRITE) |=> $stable(last_freq_ff))
      else $error("custom write changed the tuned frequency");
`endif

endmodule

`default_nettype wire
